FILE: rtl/wave_capture_settle_detector_defines.svh
// Assertion macros for the wave capture settle detector.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef WAVE_CAPTURE_SETTLE_DETECTOR_DEFINES_SVH
`define WAVE_CAPTURE_SETTLE_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define WCSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define WCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wcsd_pkg.sv
// Shared types and constants of the wave capture settle detector.
// No dependencies; every other file but the defines header imports it.
package wcsd_pkg;

  localparam int SampleW = 16;
  localparam int CountW  = 10;
  localparam int RunW    = 8;
  localparam int ThreshW = 16;
  localparam int LimitW  = 10;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  // register reset values
  localparam logic [ThreshW-1:0] THRESH_RST = 16'd40;
  localparam logic [RunW-1:0]    SETTLE_RST = 8'd16;
  localparam logic [LimitW-1:0]  LIMIT_RST  = 10'd512;

  // quiet run saturates here
  localparam logic [RunW-1:0] RUN_MAX = 8'd255;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } wcsd_op_e;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SETTLE    = 2'd1,
    REG_LIMIT     = 2'd2
  } wcsd_reg_e;

  // control of one window cell
  typedef struct packed {
    logic clear;
    logic shift;
  } wcsd_cell_ctl_t;

  // one result transaction
  typedef struct packed {
    logic [CountW-1:0] sample_count;
    logic              wave_end;
    logic              buffer_full;
    logic              capture_active;
  } wcsd_res_t;

endpackage

FILE: rtl/wcsd_if.sv
// Valid/ready channel interfaces of the wave capture settle detector.
// Depends on wcsd_pkg for field widths.
interface wcsd_in_if import wcsd_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface wcsd_out_if import wcsd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] sample_count;
  logic              wave_end;
  logic              buffer_full;
  logic              capture_active;

  modport source (output valid, output sample_count, output wave_end,
                  output buffer_full, output capture_active, input ready);
  modport sink   (input valid, input sample_count, input wave_end,
                  input buffer_full, input capture_active, output ready);
endinterface

FILE: rtl/wave_capture_settle_detector.sv
// Wave capture settle detector: takes one transaction per clock while its
// input ready is high. A start transaction clears the window and arms a
// capture; each sample transaction during a capture shifts through a row of
// WINDOW cells, updates the running sum and tests |WINDOW*sample - sum| <
// threshold. The result is registered in the output buffer; this two-entry
// output buffer keeps input ready high while one result waits, so the sustained
// rate is one transaction per cycle while the output side takes results. The window
// is cleared by a synchronous clear of all cells, so no clearing pass follows reset.
// Depends on wcsd_pkg, wcsd_if, wcsd_cell, wcsd_out_buf and the defines header.
`include "wave_capture_settle_detector_defines.svh"

module wave_capture_settle_detector import wcsd_pkg::*; #(
  parameter int WINDOW   = 8,
  parameter int MAX_WAVE = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wcsd_in_if.sink           in_i,
  wcsd_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int LogW = $clog2(WINDOW);
  localparam int SumW = SampleW + LogW;
  localparam int DevW = SumW + 1;
  localparam int LimW = ($clog2(MAX_WAVE + 1) > LimitW) ? $clog2(MAX_WAVE + 1) : LimitW;
  localparam logic signed [DevW-1:0] WinS     = DevW'(WINDOW);
  localparam logic [LimW-1:0]        MaxWaveL = LimW'(MAX_WAVE);

  // configuration registers
  logic [ThreshW-1:0] thresh_q;
  logic [RunW-1:0]    settle_q;
  logic [LimitW-1:0]  limit_q;
  logic               cfg_wr;
  wcsd_reg_e          cfg_reg;

  // detector state
  logic                   armed_q, armed_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [RunW-1:0]        quiet_q, quiet_d;
  logic [CountW-1:0]      taken_q, taken_d;

  // datapath
  logic signed [SampleW-1:0] chain [WINDOW+1];
  wcsd_cell_ctl_t            cell_ctl;
  logic signed [SumW-1:0]    sum_nx;
  logic signed [DevW-1:0]    scaled;
  logic signed [DevW-1:0]    dev;
  logic [DevW-1:0]           dev_abs;
  logic                      is_quiet;
  logic [RunW-1:0]           run_nx;
  logic                      settled;
  logic [CountW-1:0]         taken_nx;
  logic [LimW-1:0]           limit_eff;
  logic                      full;
  logic                      in_acc;
  logic                      buf_ready;
  wcsd_res_t                 res;
  wcsd_res_t                 out_res;

  // APB register port
  assign cfg_reg = wcsd_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      settle_q <= SETTLE_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_THRESHOLD: thresh_q <= pwdata[ThreshW-1:0];
        REG_SETTLE:    settle_q <= pwdata[RunW-1:0];
        REG_LIMIT:     limit_q  <= pwdata[LimitW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_THRESHOLD: prdata = DataW'(thresh_q);
      REG_SETTLE:    prdata = DataW'(settle_q);
      REG_LIMIT:     prdata = DataW'(limit_q);
      default:       prdata = '0;
    endcase
  end

  // window: row of cells, the newest sample enters cell 0
  assign chain[0] = in_i.sample;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    wcsd_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .data_i (chain[g]),
      .data_o (chain[g+1])
    );
  end

  // sum update and deviation test
  assign sum_nx    = sum_q + SumW'(in_i.sample) - SumW'(chain[WINDOW]);
  assign scaled    = DevW'(in_i.sample) * WinS;
  assign dev       = scaled - DevW'(sum_nx);
  assign dev_abs   = dev[DevW-1] ? DevW'(-dev) : DevW'(dev);
  assign is_quiet  = dev_abs < DevW'(thresh_q);
  assign run_nx    = !is_quiet ? '0 : (quiet_q == RUN_MAX) ? quiet_q : quiet_q + 1'b1;
  assign settled   = run_nx >= settle_q;
  assign taken_nx  = taken_q + 1'b1;
  assign limit_eff = (LimW'(limit_q) > MaxWaveL) ? MaxWaveL : LimW'(limit_q);
  assign full      = LimW'(taken_nx) >= limit_eff;

  assign in_acc     = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;

  // next state and result
  always_comb begin
    armed_d  = armed_q;
    sum_d    = sum_q;
    quiet_d  = quiet_q;
    taken_d  = taken_q;
    cell_ctl = '0;
    res      = '{sample_count: taken_q, wave_end: 1'b0, buffer_full: 1'b0,
                 capture_active: armed_q};
    if (in_acc) begin
      if (in_i.op == OP_START) begin
        cell_ctl.clear = 1'b1;
        sum_d          = '0;
        quiet_d        = '0;
        taken_d        = '0;
        armed_d        = 1'b1;
        res            = '{sample_count: '0, wave_end: 1'b0, buffer_full: 1'b0,
                           capture_active: 1'b1};
      end else if (armed_q) begin
        cell_ctl.shift = 1'b1;
        sum_d          = sum_nx;
        quiet_d        = run_nx;
        taken_d        = taken_nx;
        if (settled) begin
          cell_ctl.clear = 1'b1;
          sum_d          = '0;
          quiet_d        = '0;
          armed_d        = 1'b0;
        end
        if (full) begin
          armed_d = 1'b0;
        end
        res = '{sample_count: taken_nx, wave_end: settled, buffer_full: full,
                capture_active: !(settled || full)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      sum_q   <= '0;
      quiet_q <= '0;
      taken_q <= '0;
    end else begin
      armed_q <= armed_d;
      sum_q   <= sum_d;
      quiet_q <= quiet_d;
      taken_q <= taken_d;
    end
  end

  // result buffer
  wcsd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .data_o  (out_res),
    .ready_i (out_o.ready)
  );

  assign out_o.sample_count   = out_res.sample_count;
  assign out_o.wave_end       = out_res.wave_end;
  assign out_o.buffer_full    = out_res.buffer_full;
  assign out_o.capture_active = out_res.capture_active;

  // checks
  `WCSD_ASSERT_NOW(a_end_stops_capture,
                   out_o.valid && (out_o.wave_end || out_o.buffer_full),
                   !out_o.capture_active,
                   "capture still active after wave end or full buffer")
  `WCSD_ASSERT_NEXT(a_start_clears,
                    in_acc && (in_i.op == OP_START),
                    armed_q && (taken_q == '0) && (sum_q == '0) && (quiet_q == '0),
                    "start did not clear detector")
  `WCSD_ASSERT_NEXT(a_settle_clears,
                    in_acc && (in_i.op == OP_SAMPLE) && armed_q && settled,
                    !armed_q && (sum_q == '0) && (quiet_q == '0),
                    "wave end did not clear window")

endmodule

FILE: rtl/wcsd_cell.sv
// One window cell: holds one sample and passes it to the next cell on shift.
// Depends on wcsd_pkg.
module wcsd_cell import wcsd_pkg::*; (
  input  logic                      clk_i,
  input  wcsd_cell_ctl_t            ctl_i,
  input  logic signed [SampleW-1:0] data_i,
  output logic signed [SampleW-1:0] data_o
);

  logic signed [SampleW-1:0] data_q, data_d;

  // clear wins over shift
  always_comb begin
    data_d = data_q;
    if (ctl_i.clear) begin
      data_d = '0;
    end else if (ctl_i.shift) begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/wcsd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on wcsd_pkg for the result type.
module wcsd_out_buf import wcsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wcsd_res_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  output wcsd_res_t data_o,
  input  logic      ready_i
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  wcsd_res_t out_q, out_d;
  wcsd_res_t skid_q, skid_d;

  // pop first, then place the new transaction in the first free slot
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_d) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
